/* hdl/lef_pkg.sv */
// Shared types, constants and the Laplacian kernel of the 3x3 edge filter.
`timescale 1ns / 1ps

package lef_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W    = 8;
  localparam int OCOL_W   = 10;
  localparam int OROW_W   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int IMG_W_W  = 11;
  localparam int IMG_H_W  = 13;
  localparam int MDATA_W  = 32;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = IMG_W_W'(1024);
  localparam logic [IMG_H_W-1:0] IMG_H_RST = IMG_H_W'(1024);

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Row 0 oldest, row 2 newest; column 2 newest.
  typedef logic [8:0][PIX_W-1:0] win_t;

  function automatic logic [PIX_W-1:0] lef_laplace(win_t w, logic dr, logic dc);
    logic signed [12:0] acc;
    logic [PIX_W-1:0]   t;
    int                 ri;
    int                 cj;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ri = i + int'(dr);
        cj = j + int'(dc);
        t  = (ri > 2 || cj > 2) ? '0 : w[4'(ri * 3 + cj)];
        if (i == 1 && j == 1) begin
          acc = acc + $signed({2'b00, t, 3'b000});
        end else begin
          acc = acc - $signed({5'b00000, t});
        end
      end
    end
    if (acc < 0) begin
      return '0;
    end else if (acc > 13'sd255) begin
      return '1;
    end
    return acc[PIX_W-1:0];
  endfunction

endpackage

/* hdl/lef_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module lef_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/laplacian_edge_filter_3x3.sv */
// Top level of the 3x3 Laplacian edge filter on a raster pixel stream.
//
// Slave stream: s_tdata_i carries the red byte of the next pixel in raster
// order, one transaction per pixel. Master stream: one transaction per output
// pixel; m_tdata_o holds the clamped Laplacian, column and row, m_tlast_o marks
// the last result caused by an input pixel and m_tuser_o the frame's final
// pixel. Output (c-1, r-1) follows input (c, r); a row end adds the last column,
// the last row adds its own outputs, so one pixel yields 0 to 4 results.
// The config port writes image_width (index 0) or image_height (index 1) and
// restarts the frame; write only while the stream is idle.
// An input transaction reaches its first result via line store read, window
// update and output register. Throughput: one pixel per cycle while the
// receiver accepts and a pixel yields at most one result; more stall the input.
// Line stores are one 1R1W RAM of 2x8 bits per column, read-modify-written
// once per pixel. Reset clears counters, window and pipeline valids; RAM
// contents are never read before written. A stalled receiver holds the
// output register and backpressures through the window stage to s_tready_o.
`timescale 1ns / 1ps

module laplacian_edge_filter_3x3
  import lef_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [PIX_W-1:0]      s_tdata_i,   // pixel_red
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [MDATA_W-1:0]    m_tdata_o,   // gray_level, out_col, out_row, 2'b0
  output logic                  m_tlast_o,
  output logic                  m_tuser_o,   // frame_done
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = CW + 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW = RW + 1;
  localparam int LW = 2 * PIX_W;

  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;
  logic [EW-1:0]      eff_w;
  logic [HW-1:0]      eff_h;
  logic [CW-1:0]      col_q, col_d, c_eff;
  logic [RW-1:0]      row_q, row_d, r_eff;
  logic               last_col, last_row, s_acc, cfg_hit;
  logic [3:0]         mask0;

  logic               p1_v_q, p1_adv;
  logic [PIX_W-1:0]   p1_pix_q;
  logic [CW-1:0]      p1_col_q;
  logic [RW-1:0]      p1_row_q;
  logic               p1_ge1_q, p1_ge2_q;
  logic [3:0]         p1_mask_q;
  logic               fwd_q;
  logic [LW-1:0]      fwd_data_q, ram_rdata, line_rd, line_wr;
  win_t               win_q, win_d;

  win_t               e_win_q;
  logic [3:0]         e_mask_q, e_sel, e_rest;
  logic [CW-1:0]      e_col_q;
  logic [RW-1:0]      e_row_q;
  logic               e_free, e_fire, out_ok, e_dr, e_dc;
  logic [CW-1:0]      o_col;
  logic [RW-1:0]      o_row;

  logic               m_tvalid_q, m_tlast_q, m_tuser_q;
  logic [MDATA_W-1:0] m_tdata_q;

  // Effective geometry.
  always_comb begin
    if (width_q == '0) begin
      eff_w = EW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_q);
    end
  end

  assign c_eff    = ({1'b0, col_q} >= eff_w) ? CW'(eff_w - EW'(1)) : col_q;
  assign r_eff    = ({1'b0, row_q} >= eff_h) ? RW'(eff_h - HW'(1)) : row_q;
  assign last_col = ({1'b0, c_eff} == eff_w - EW'(1));
  assign last_row = ({1'b0, r_eff} == eff_h - HW'(1));
  assign mask0    = {last_row && last_col, last_row && (c_eff != '0),
                     (r_eff != '0) && last_col, (r_eff != '0) && (c_eff != '0)};

  always_comb begin
    col_d = c_eff + CW'(1);
    row_d = r_eff;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : r_eff + RW'(1);
    end
  end

  assign s_tready_o = !p1_v_q || p1_adv;
  assign s_acc      = s_tvalid_i && s_tready_o;
  assign cfg_hit    = cfg_we_i &&
                      (cfg_idx_i == CFG_IMAGE_WIDTH || cfg_idx_i == CFG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMG_W_RST;
      height_q <= IMG_H_RST;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_hit) begin
      if (cfg_idx_i == CFG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i[IMG_W_W-1:0];
      end else begin
        height_q <= cfg_data_i;
      end
      col_q <= '0;
      row_q <= '0;
    end else if (s_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line stores: [15:8] row r-2, [7:0] row r-1.
  lef_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (p1_adv),
    .waddr_i (p1_col_q),
    .wdata_i (line_wr),
    .re_i    (s_acc),
    .raddr_i (c_eff),
    .rdata_o (ram_rdata)
  );

  assign line_rd = fwd_q ? fwd_data_q : ram_rdata;
  assign line_wr = {line_rd[PIX_W-1:0], p1_pix_q};
  assign p1_adv  = p1_v_q && e_free;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i*3]     = (p1_col_q == '0) ? '0 : win_q[i*3+1];
      win_d[i*3 + 1] = (p1_col_q == '0) ? '0 : win_q[i*3+2];
    end
    win_d[2] = p1_ge2_q ? line_rd[LW-1:PIX_W] : '0;
    win_d[5] = p1_ge1_q ? line_rd[PIX_W-1:0] : '0;
    win_d[8] = p1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
      win_q  <= '0;
    end else begin
      if (s_acc) begin
        p1_v_q <= 1'b1;
        fwd_q  <= p1_adv && (p1_col_q == c_eff);
      end else if (p1_adv) begin
        p1_v_q <= 1'b0;
      end
      if (cfg_hit) begin
        win_q <= '0;
      end else if (p1_adv) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      p1_pix_q   <= s_tdata_i;
      p1_col_q   <= c_eff;
      p1_row_q   <= r_eff;
      p1_ge1_q   <= (r_eff != '0);
      p1_ge2_q   <= (r_eff > RW'(1));
      p1_mask_q  <= mask0;
      fwd_data_q <= line_wr;
    end
  end

  // Result emission, lowest pending result first.
  assign out_ok = !m_tvalid_q || m_tready_i;
  assign e_sel  = e_mask_q & (~e_mask_q + 4'd1);
  assign e_rest = e_mask_q & ~e_sel;
  assign e_fire = out_ok && (e_mask_q != '0);
  assign e_free = (e_mask_q == '0) || (out_ok && (e_rest == '0));
  assign e_dr   = e_sel[2] || e_sel[3];
  assign e_dc   = e_sel[1] || e_sel[3];
  assign o_col  = e_dc ? e_col_q : e_col_q - CW'(1);
  assign o_row  = e_dr ? e_row_q : e_row_q - RW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_mask_q   <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (p1_adv) begin
        e_mask_q <= p1_mask_q;
      end else if (e_fire) begin
        e_mask_q <= e_rest;
      end
      if (e_fire) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_adv) begin
      e_win_q <= win_d;
      e_col_q <= p1_col_q;
      e_row_q <= p1_row_q;
    end
    if (e_fire) begin
      m_tdata_q <= {2'b00, OROW_W'(o_row), OCOL_W'(o_col), lef_laplace(e_win_q, e_dr, e_dc)};
      m_tlast_q <= (e_rest == '0);
      m_tuser_q <= e_sel[3];
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tlast_o  = m_tlast_q;
  assign m_tuser_o  = m_tuser_q;

  a_fwd_only_single_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q && p1_v_q |-> eff_w == EW'(1))
    else $error("line store forwarding with width above one");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o |-> m_tlast_o)
    else $error("frame end not marked as last result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> p1_v_q && e_mask_q != '0)
    else $error("input stalled without a busy pipeline");

  a_done_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_fire && e_sel[3] |-> ({1'b0, e_col_q} == eff_w - EW'(1)) &&
                           ({1'b0, e_row_q} == eff_h - HW'(1)))
    else $error("frame end emitted away from the last pixel");

endmodule

/* dv/tb_laplacian_edge_filter_3x3.sv */
// Self-checking testbench for the 3x3 Laplacian edge filter with a stream predictor.
`timescale 1ns / 1ps

module tb_laplacian_edge_filter_3x3;
  import lef_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int RAND_PIXELS = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic [PIX_W-1:0]  gray;
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic              last;
    logic              done;
  } filt_px_t;

  typedef enum logic [2:0] {
    ST_SET_WIDTH,
    ST_SET_HEIGHT,
    ST_SET_SPARE,
    ST_PIX,
    ST_PIX_NONE,
    ST_PIX_ONE
  } step_kind_e;

  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_DATA_W-1:0] value;
    logic [PIX_W-1:0]      gray;
  } step_t;

  localparam int N_STEPS = 25;

  step_t script [N_STEPS] = '{
    '{ST_PIX_NONE,   13'd255,  8'd0},
    '{ST_PIX_NONE,   13'd0,    8'd0},
    '{ST_PIX_NONE,   13'd170,  8'd0},
    '{ST_SET_SPARE,  13'h1FFF, 8'd0},
    '{ST_PIX_NONE,   13'd85,   8'd0},
    '{ST_SET_WIDTH,  13'd1,    8'd0},
    '{ST_SET_HEIGHT, 13'd1,    8'd0},
    '{ST_PIX_ONE,    13'd0,    8'd0},
    '{ST_PIX_ONE,    13'd31,   8'd248},
    '{ST_PIX_ONE,    13'd32,   8'd255},
    '{ST_PIX_ONE,    13'd255,  8'd255},
    '{ST_SET_WIDTH,  13'd0,    8'd0},
    '{ST_SET_HEIGHT, 13'd0,    8'd0},
    '{ST_PIX_ONE,    13'd1,    8'd8},
    '{ST_SET_WIDTH,  13'd3,    8'd0},
    '{ST_SET_HEIGHT, 13'd3,    8'd0},
    '{ST_PIX,        13'd255,  8'd0},
    '{ST_PIX,        13'd0,    8'd0},
    '{ST_PIX,        13'd255,  8'd0},
    '{ST_PIX,        13'd0,    8'd0},
    '{ST_PIX,        13'd255,  8'd0},
    '{ST_PIX,        13'd0,    8'd0},
    '{ST_PIX,        13'd255,  8'd0},
    '{ST_PIX,        13'd0,    8'd0},
    '{ST_PIX,        13'd255,  8'd0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_tvalid_i;
  logic                  s_tready_o;
  logic [PIX_W-1:0]      s_tdata_i;    // pixel_red
  logic                  m_tvalid_o;
  logic                  m_tready_i;
  logic [MDATA_W-1:0]    m_tdata_o;    // gray_level, out_col, out_row, 2'b0
  logic                  m_tlast_o;
  logic                  m_tuser_o;    // frame_done
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  laplacian_edge_filter_3x3 u_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state
  int unsigned      width_reg;
  int unsigned      height_reg;
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [PIX_W-1:0] taps [9];
  logic [PIX_W-1:0] prev_line [MAX_WIDTH_DEF];
  logic [PIX_W-1:0] prev2_line [MAX_WIDTH_DEF];

  filt_px_t filtered_queue [$];
  filt_px_t head_px;
  filt_px_t got_px;

  int  mismatches = 0;
  int  pixels_in = 0;
  int  pixels_out = 0;
  int  geometries = 0;
  int  cycles = 0;
  int  stall_left = 0;
  bit  sender_steady = 1'b0;
  bit  sink_steady = 1'b0;

  function automatic int unsigned eff_width(int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return v;
  endfunction

  function automatic int unsigned eff_height(int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
    return v;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] lap_response(int dr, int dc);
    int acc;
    int v;
    acc = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i + dr > 2 || j + dc > 2) begin
          v = 0;
        end else begin
          v = taps[(i + dr) * 3 + j + dc];
        end
        acc += (i == 1 && j == 1) ? 8 * v : -v;
      end
    end
    if (acc < 0) return '0;
    if (acc > 255) return '1;
    return PIX_W'(acc);
  endfunction

  function automatic void clear_frame();
    foreach (taps[k]) taps[k] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IMAGE_WIDTH: begin
        width_reg = data[IMG_W_W-1:0];
      end
      CFG_IMAGE_HEIGHT: begin
        height_reg = data[IMG_H_W-1:0];
      end
      default: begin
        return;
      end
    endcase
    clear_frame();
  endfunction

  function automatic void filter_pixel(logic [PIX_W-1:0] red, bit keep);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    filt_px_t    outs [$];
    w = eff_width(width_reg);
    h = eff_height(height_reg);
    c = col_pos;
    r = row_pos;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    if (c == 0) foreach (taps[k]) taps[k] = '0;
    for (int i = 0; i < 3; i++) begin
      taps[i * 3]     = taps[i * 3 + 1];
      taps[i * 3 + 1] = taps[i * 3 + 2];
    end
    taps[2] = (r >= 2) ? prev2_line[c] : '0;
    taps[5] = (r >= 1) ? prev_line[c] : '0;
    taps[8] = red;
    prev2_line[c] = prev_line[c];
    prev_line[c]  = red;
    if (r >= 1) begin
      if (c >= 1) begin
        outs.push_back(filt_px_t'{lap_response(0, 0), OCOL_W'(c - 1), OROW_W'(r - 1), 1'b0, 1'b0});
      end
      if (c == w - 1) begin
        outs.push_back(filt_px_t'{lap_response(0, 1), OCOL_W'(c), OROW_W'(r - 1), 1'b0, 1'b0});
      end
    end
    if (r == h - 1) begin
      if (c >= 1) begin
        outs.push_back(filt_px_t'{lap_response(1, 0), OCOL_W'(c - 1), OROW_W'(r), 1'b0, 1'b0});
      end
      if (c == w - 1) begin
        outs.push_back(filt_px_t'{lap_response(1, 1), OCOL_W'(c), OROW_W'(r), 1'b0, 1'b1});
      end
    end
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    if (keep) foreach (outs[k]) filtered_queue.push_back(outs[k]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Drop the stream, drain all outstanding results, then let the pipeline empty.
  task automatic settle();
    @(negedge clk_i);
    s_tvalid_i <= 1'b0;
    while (filtered_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pixel(logic [PIX_W-1:0] red, bit keep);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= red;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    filter_pixel(red, keep);
    pixels_in++;
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready_i <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 5) == 0) begin
      stall_left = pick_gap();
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got_px = filt_px_t'{m_tdata_o[PIX_W-1:0],
                          m_tdata_o[PIX_W+OCOL_W-1:PIX_W],
                          m_tdata_o[PIX_W+OCOL_W+OROW_W-1:PIX_W+OCOL_W],
                          m_tlast_o, m_tuser_o};
      if (filtered_queue.size() == 0) begin
        $error("unexpected output pixel col %0d row %0d gray %0d",
               got_px.col, got_px.row, got_px.gray);
        mismatches++;
      end else begin
        head_px = filtered_queue.pop_front();
        check_field("gray_level", head_px.gray, got_px.gray);
        check_field("out_col", head_px.col, got_px.col);
        check_field("out_row", head_px.row, got_px.row);
        check_field("run_last", head_px.last, got_px.last);
        check_field("frame_done", head_px.done, got_px.done);
        pixels_out++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, filtered_queue.size());
      $display("[laplacian_edge_filter_3x3] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int                    mode;
    int                    npx;
    int                    frame;
    int                    mid;
    int                    brk;
    int                    phase;
    int                    rand_pixels;
    int                    roll;
    int unsigned           wreg;
    int unsigned           hreg;
    logic [PIX_W-1:0]      red;
    logic [CFG_DATA_W-1:0] wdata;

    rst_ni     = 1'b0;
    s_tvalid_i = 1'b0;
    s_tdata_i  = '0;
    m_tready_i = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_IMAGE_WIDTH;
    cfg_data_i = '0;
    width_reg  = IMG_W_RST;
    height_reg = IMG_H_RST;
    foreach (prev_line[k]) prev_line[k] = '0;
    foreach (prev2_line[k]) prev2_line[k] = '0;
    clear_frame();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[k]) begin
      case (script[k].kind)
        ST_SET_WIDTH: begin
          write_reg(CFG_IMAGE_WIDTH, script[k].value);
          geometries++;
        end
        ST_SET_HEIGHT: begin
          write_reg(CFG_IMAGE_HEIGHT, script[k].value);
        end
        ST_SET_SPARE: begin
          write_reg(CFG_SPARE_3, script[k].value);
        end
        ST_PIX: begin
          send_pixel(script[k].value[PIX_W-1:0], 1'b1);
        end
        ST_PIX_NONE: begin
          send_pixel(script[k].value[PIX_W-1:0], 1'b0);
        end
        ST_PIX_ONE: begin
          send_pixel(script[k].value[PIX_W-1:0], 1'b0);
          filtered_queue.push_back(filt_px_t'{script[k].gray, '0, '0, 1'b1, 1'b1});
        end
        default: begin
        end
      endcase
    end

    phase = 0;
    rand_pixels = 0;
    while (rand_pixels < RAND_PIXELS) begin
      mode = (phase < 2) ? phase : $urandom_range(0, 9);
      case (mode)
        0: begin
          wreg = $urandom_range(0, 1) ? MAX_WIDTH_DEF : $urandom_range(MAX_WIDTH_DEF + 1, 2047);
          hreg = $urandom_range(0, 1);
          npx  = 30;
        end
        1: begin
          wreg = $urandom_range(0, 1);
          hreg = $urandom_range(0, 1) ? MAX_HEIGHT_DEF : $urandom_range(MAX_HEIGHT_DEF + 1, 8191);
          npx  = 30;
        end
        default: begin
          wreg  = $urandom_range(0, 8);
          hreg  = $urandom_range(0, 6);
          frame = eff_width(wreg) * eff_height(hreg);
          npx   = frame * $urandom_range(1, 2);
          if ($urandom_range(0, 3) == 0) npx += $urandom_range(1, frame);
        end
      endcase
      wdata = CFG_DATA_W'(wreg) | (CFG_DATA_W'($urandom_range(0, 3)) << IMG_W_W);
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(hreg));
        write_reg(CFG_IMAGE_WIDTH, wdata);
      end else begin
        write_reg(CFG_IMAGE_WIDTH, wdata);
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(hreg));
      end
      geometries++;
      sender_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      mid = $urandom_range(1, npx - 1);
      brk = (phase == 2) ? 1 : $urandom_range(0, 4);
      for (int k = 0; k < npx; k++) begin
        if (k == mid) begin
          if (brk == 1) begin
            settle();
          end else if (brk == 2) begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                      CFG_DATA_W'($urandom_range(0, 8191)));
          end
        end
        roll = $urandom_range(0, 9);
        if (roll < 2) begin
          red = '0;
        end else if (roll < 4) begin
          red = '1;
        end else begin
          red = PIX_W'($urandom_range(0, 255));
        end
        send_pixel(red, 1'b1);
      end
      rand_pixels += npx;
      phase++;
    end

    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    settle();
    repeat (20) @(posedge clk_i);

    $display("Streamed %0d pixels over %0d image geometries, from 1x1 up to full width",
             pixels_in, geometries);
    $display("and height; compared %0d filter outputs, %0d mismatches.",
             pixels_out, mismatches);
    if (mismatches == 0 && filtered_queue.size() == 0) begin
      $display("[laplacian_edge_filter_3x3] OK");
    end else begin
      $display("[laplacian_edge_filter_3x3] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lef_pkg.sv
hdl/lef_ram.sv
hdl/laplacian_edge_filter_3x3.sv
dv/tb_laplacian_edge_filter_3x3.sv
